// ----- rtl/core/hotp_pkg.sv -----
// Shared types and constants for the HOTP SHA-1 code generator.
package hotp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_TRUNC,
        ST_DEC,
        ST_LUHN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        CFG_KEY_UPPER    = 3'd0,
        CFG_KEY_MIDDLE   = 3'd1,
        CFG_KEY_LOWER    = 3'd2,
        CFG_DIGIT_COUNT  = 3'd3,
        CFG_ADD_CHECKSUM = 3'd4,
        CFG_RESP_CAP     = 3'd5
    } t_cfg_idx;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;
    localparam logic [31:0] LEN_INNER = 32'd576;   // 72 bytes in bits
    localparam logic [31:0] LEN_OUTER = 32'd672;   // 84 bytes in bits

    // Round constant for round number t.
    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) k = 32'h5A827999;
        else if (t < 7'd40) k = 32'h6ED9EBA1;
        else if (t < 7'd60) k = 32'h8F1BBCDC;
        else k = 32'hCA62C1D6;
        return k;
    endfunction

    // Luhn doubling table.
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0: r = 4'd0;
            4'd1: r = 4'd2;
            4'd2: r = 4'd4;
            4'd3: r = 4'd6;
            4'd4: r = 4'd8;
            4'd5: r = 4'd1;
            4'd6: r = 4'd3;
            4'd7: r = 4'd5;
            4'd8: r = 4'd7;
            4'd9: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/hotp_sha1_round.sv -----
// SHA-1 compression engine: one round per cycle with a rolling 16-word schedule.
module hotp_sha1_round (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,      // load block and chaining value
    input  logic [511:0] i_block,      // word 0 in the top bits
    input  logic [159:0] i_hin,
    output logic         o_done,       // pulses when o_hout is valid
    output logic [159:0] o_hout
);
    import hotp_pkg::*;

    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [511:0] r_w;
    logic [159:0] r_h;
    logic [6:0]   r_t;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  f, rnd_sum, w_mix, w_new, w0;

    assign w0 = r_w[511:480];

    always_comb begin
        if (r_t < 7'd20) f = (r_b & r_c) | (~r_b & r_d);
        else if (r_t < 7'd40 || r_t >= 7'd60) f = r_b ^ r_c ^ r_d;
        else f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
        rnd_sum = {r_a[26:0], r_a[31:27]} + f + r_e + sha1_k(r_t) + w0;
        // New word W[t+16] = rotl1(W[t+13]^W[t+8]^W[t+2]^W[t]).
        w_mix = r_w[95:64] ^ r_w[255:224] ^ r_w[447:416] ^ r_w[511:480];
        w_new = {w_mix[30:0], w_mix[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (r_busy) begin
                r_t <= r_t + 7'd1;
                if (r_t == 7'd79) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_block;
            r_h <= i_hin;
            {r_a, r_b, r_c, r_d, r_e} <= i_hin;
        end else if (r_busy) begin
            r_w <= {r_w[479:0], w_new};
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= rnd_sum;
        end
    end

    assign o_done = r_done;
    assign o_hout = {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                     r_h[63:32] + r_d, r_h[31:0] + r_e};

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held more than one cycle");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_t) == 7'd79) else $error("done without final round");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
`endif
endmodule

// ----- rtl/core/hotp_sha1_code_generator.sv -----
// Top level of the HOTP (HMAC-SHA1) code generator with decimal and Luhn stages.
//
// Channel  Direction  Handshake              Word
// s_axis   in         s_axis_tvalid/tready   counter_value[63:0]
// m_axis   out        m_axis_tvalid/tready   status, code_digits, code_length, truncated
// cfg      in         i_cfg_valid/o_cfg_ready register index and 64-bit data
//
// One word takes four SHA-1 blocks, each a load, 80 rounds at one per cycle in the
// shared round engine, a done pulse and a chaining update; then truncation, decimal
// conversion (one digit per cycle) and Luhn summing (passed straight through without a
// check digit or on error), then the output state, which waits while it is stalled,
// and the idle state before the next word is accepted.
// The input is not ready while a word is in work or its result waits.
// Reset is synchronous and active low; config, state and valid registers are reset.
// A stalled output holds its word; configuration writes are always accepted.
module hotp_sha1_code_generator #(
    parameter int KEY_BYTES = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [63:0] counter_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [0] status, [64:1] code_digits,
                                         // [69:65] code_length, [100:70] truncated_value
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import hotp_pkg::*;

    // Configuration registers.
    logic [63:0] r_key_upper, r_key_middle;
    logic [31:0] r_key_lower;
    logic [3:0]  r_digit_count;
    logic        r_add_checksum;
    logic [7:0]  r_resp_cap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper    <= '0;
            r_key_middle   <= '0;
            r_key_lower    <= '0;
            r_digit_count  <= 4'd6;
            r_add_checksum <= 1'b0;
            r_resp_cap     <= 8'd17;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_UPPER:    r_key_upper    <= i_cfg_data;
                CFG_KEY_MIDDLE:   r_key_middle   <= i_cfg_data;
                CFG_KEY_LOWER:    r_key_lower    <= i_cfg_data[31:0];
                CFG_DIGIT_COUNT:  r_digit_count  <= i_cfg_data[3:0];
                CFG_ADD_CHECKSUM: r_add_checksum <= i_cfg_data[0];
                CFG_RESP_CAP:     r_resp_cap     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The key padded to 20 bytes; bytes at or past KEY_BYTES read as zero.
    logic [159:0] key_raw, key_mask, key160;
    assign key_raw = {r_key_upper, r_key_middle, r_key_lower};
    always_comb begin
        for (int i = 0; i < 20; i++)
            key_mask[159 - 8*i -: 8] = (i < KEY_BYTES) ? 8'hFF : 8'h00;
    end
    assign key160 = key_raw & key_mask;

    // Sequencer.
    t_state       r_state, n_state;
    logic [1:0]   r_blk;        // 0 inner key, 1 inner msg, 2 outer key, 3 outer msg
    logic [63:0]  r_ctr;
    logic [159:0] r_hh;         // chaining value
    logic [159:0] r_inner;
    logic         eng_start, eng_done;
    logic [511:0] blk;
    logic [159:0] hout;

    logic [30:0]  r_trunc;
    logic [30:0]  r_v;
    logic [3:0]   r_cnt;        // digits remaining
    logic [63:0]  r_digits;     // built from the right end
    logic [3:0]   r_idx;        // Luhn position from the right
    logic [3:0]   r_sum;
    logic         r_status;
    logic [4:0]   r_len;
    logic         r_ovalid;

    hotp_sha1_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_block (blk),
        .i_hin   (r_hh),
        .o_done  (eng_done),
        .o_hout  (hout)
    );

    always_comb begin
        unique case (r_blk)
            2'd0: blk = {key160 ^ {20{IPAD}}, {44{IPAD}}};
            2'd1: blk = {r_ctr, 8'h80, 376'd0, 32'd0, LEN_INNER};
            2'd2: blk = {key160 ^ {20{OPAD}}, {44{OPAD}}};
            default: blk = {r_inner, 8'h80, 280'd0, 32'd0, LEN_OUTER};
        endcase
    end

    // Dynamic truncation from the final digest.
    logic [3:0]   off;
    logic [159:0] dsh;
    assign off = hout[3:0];
    assign dsh = hout << {off, 3'b000};

    // Division by ten of a 31-bit value by reciprocal multiply and correction.
    logic [63:0] q_mul;
    logic [30:0] q0, q;
    logic [34:0] rem0;
    logic [3:0]  dig;
    assign q_mul = {33'd0, r_v} * 64'd3435973837;
    assign q0    = {3'd0, q_mul[62:35]};
    always_comb begin
        rem0 = {4'd0, r_v} - {4'd0, q0} * 35'd10;
        if (rem0 >= 35'd10) begin
            q   = q0 + 31'd1;
            dig = 4'(rem0 - 35'd10);
        end else begin
            q   = q0;
            dig = rem0[3:0];
        end
    end

    logic [8:0] need;
    assign need = {5'd0, r_digit_count} + {8'd0, r_add_checksum} + 9'd1;

    // Luhn: digit at position r_idx from the right of the code digits.
    logic [3:0] ld, lterm;
    logic [4:0] lsum;
    assign ld    = r_digits[{r_idx, 2'b00} +: 4];
    assign lterm = r_idx[0] ? ld : luhn_dbl(ld);
    assign lsum  = {1'b0, r_sum} + {1'b0, lterm};

    always_comb begin
        n_state   = r_state;
        eng_start = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_LOAD;
            ST_LOAD:  begin eng_start = 1'b1; n_state = ST_ROUND; end
            ST_ROUND: if (eng_done) n_state = ST_ADD;
            ST_ADD:   n_state = (r_blk == 2'd3) ? ST_TRUNC : ST_LOAD;
            ST_TRUNC: n_state = ST_DEC;
            ST_DEC:   if (r_cnt == 4'd0) n_state = ST_LUHN;
            ST_LUHN:  if (!r_add_checksum || r_status || r_idx == r_digit_count)
                          n_state = ST_OUT;
            ST_OUT:   if (m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) begin
                r_ctr <= s_axis_tdata;
                r_blk <= 2'd0;
                r_hh  <= SHA1_IV;
            end
            ST_ROUND: if (eng_done) begin
                unique case (r_blk)
                    2'd1: begin r_inner <= hout; r_hh <= SHA1_IV; end
                    default: r_hh <= hout;
                endcase
            end
            ST_ADD: r_blk <= r_blk + 2'd1;
            ST_TRUNC: begin
                r_trunc  <= dsh[158:128];
                r_v      <= dsh[158:128];
                r_cnt    <= r_digit_count;
                r_digits <= '0;
                r_idx    <= '0;
                r_sum    <= '0;
                r_status <= need > {1'b0, r_resp_cap};
            end
            ST_DEC: if (r_cnt != 4'd0) begin
                r_digits <= {dig, r_digits[63:4]};
                r_v      <= q;
                r_cnt    <= r_cnt - 4'd1;
            end else begin
                // Right-align the code digits: digit_count nibbles at the bottom.
                // With no digits the register is still all zeros.
                r_digits <= r_digits >> {~r_digit_count + 4'd1 == 4'd0 ? 7'd0 :
                             {1'b0, 4'(4'd0 - r_digit_count), 2'b00}};
            end
            ST_LUHN: if (r_add_checksum && !r_status && r_idx != r_digit_count) begin
                r_sum <= (lsum >= 5'd10) ? 4'(lsum - 5'd10) : lsum[3:0];
                r_idx <= r_idx + 4'd1;
            end
            default: ;
        endcase
    end

    // Final packing: right-aligned digits, optional check digit, then left-justify.
    logic [3:0]  chk;
    logic [67:0] allr;
    logic [4:0]  total;
    logic [63:0] packed_d;
    assign chk   = (r_sum == 4'd0) ? 4'd0 : 4'(4'd10 - r_sum);
    assign total = {1'b0, r_digit_count} + {4'd0, r_add_checksum};
    assign allr  = r_add_checksum ? {r_digits, chk} : {4'd0, r_digits};
    assign packed_d = (total == 5'd0) ? 64'd0 :
                      64'(allr << {5'd16 - total, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else          r_ovalid <= (n_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LUHN && n_state == ST_OUT) begin
            r_len <= r_status ? 5'd0 : total;
        end
    end

    logic [63:0] r_out_digits;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LUHN && n_state == ST_OUT)
            r_out_digits <= r_status ? 64'd0 : packed_d;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_trunc, r_len, r_out_digits, r_status};

`ifndef SYNTHESIS
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input ready with result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_status |-> r_len == 5'd0 && r_out_digits == 64'd0)
        else $error("error result carries digits");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_len <= 5'd16) else $error("code length too large");
`endif
endmodule

// ----- bench/hotp_sha1_code_generator_test.sv -----
// Self-checking bench for the HOTP SHA-1 code generator: HMAC, truncation, digits and Luhn.
module hotp_sha1_code_generator_test;
    import hotp_pkg::*;

    // Expected result word, one per accepted counter.
    typedef struct packed {
        logic [30:0] truncated;
        logic [4:0]  length;
        logic [63:0] digits;
        logic        status;
    } t_code;

    // A queued action: either a counter word or a register write.
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [63:0] data;
        bit          drain;   // wait until idle before this action
    } t_action;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    hotp_sha1_code_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [63:0] key_hi, key_mid;
    logic [31:0] key_lo;
    logic [3:0]  num_digits;
    logic        want_luhn;
    logic [7:0]  buf_size;

    t_action     pending[$];
    t_code       expected_codes[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle = 0;   // percent
    int          recv_stall = 0;  // percent
    int          hold_off = 0;    // cycles left of a long receiver stall
    bit          held = 0;        // the long stall has been done
    bit          stim_done = 0;
    bit          s_acc = 0;       // input word taken at the last rising edge
    bit          c_acc = 0;       // register write taken at the last rising edge

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One SHA-1 compression over a 512-bit block, first byte in the top bits.
    function automatic logic [159:0] compress(input logic [159:0] h, input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // Full HOTP computation under the shadow registers.
    function automatic t_code hotp_code(input logic [63:0] counter);
        logic [511:0] kblk, blk;
        logic [159:0] h, inner;
        logic [7:0]   dg[20];
        logic [31:0]  v;
        logic [3:0]   dig[16];
        int           off, sum, total;
        t_code        r;
        kblk = {key_hi, key_mid, key_lo, 352'h0};
        // Inner hash: key block, then counter with padding for 72 bytes.
        h = compress(SHA1_IV, kblk ^ {64{IPAD}});
        blk = {counter, 8'h80, 376'h0, 64'd576};
        inner = compress(h, blk);
        // Outer hash: key block, then inner digest with padding for 84 bytes.
        h = compress(SHA1_IV, kblk ^ {64{OPAD}});
        blk = {inner, 8'h80, 280'h0, 64'd672};
        h = compress(h, blk);
        for (int i = 0; i < 20; i++) dg[i] = h[159 - 8 * i -: 8];
        off = dg[19][3:0];
        v = {1'b0, dg[off][6:0], dg[off+1], dg[off+2], dg[off+3]};
        r = '0;
        r.truncated = v[30:0];
        if (int'(num_digits) + int'(want_luhn) + 1 > int'(buf_size)) begin
            r.status = 1;
            return r;
        end
        for (int i = int'(num_digits); i > 0; i--) begin
            dig[i-1] = 4'(v % 10);
            v = v / 10;
        end
        total = num_digits + want_luhn;
        if (want_luhn) begin
            sum = 0;
            for (int i = 0; i < num_digits; i++)
                sum += (i % 2 == 0) ? luhn_dbl(dig[num_digits-1-i]) : dig[num_digits-1-i];
            sum = sum % 10;
            dig[num_digits] = 4'(sum ? 10 - sum : 0);
        end
        for (int i = 0; i < total; i++) r.digits[63 - 4 * i -: 4] = dig[i];
        r.length = 5'(total);
        return r;
    endfunction

    task automatic add_item(input logic [63:0] cnt, input bit drain = 0);
        t_action a;
        a.is_cfg = 0; a.idx = CFG_KEY_UPPER; a.data = cnt; a.drain = drain;
        pending.push_back(a);
    endtask

    task automatic add_write(input t_cfg_idx idx, input logic [63:0] val);
        t_action a;
        a.is_cfg = 1; a.idx = idx; a.data = val; a.drain = 1;
        pending.push_back(a);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random counters: mostly full-width, some near the extremes.
    function automatic logic [63:0] rand_counter();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 20));
            1: return ~64'($urandom_range(0, 20));
            default: return rand64();
        endcase
    endfunction

    // Build the stimulus: directed block first, then random phases.
    initial begin
        logic [3:0] nd;
        // Directed: reset settings with extreme counters.
        add_item(64'h0); add_item(64'h1); add_item('1); add_item(64'h8000_0000_0000_0000);
        // The published test key "12345678901234567890".
        add_write(CFG_KEY_UPPER, 64'h3132333435363738);
        add_write(CFG_KEY_MIDDLE, 64'h3930313233343536);
        add_write(CFG_KEY_LOWER, 64'h37383930);
        add_item(64'd0); add_item(64'd1); add_item(64'd9);
        // More than ten digits with a check digit, full-width buffer.
        add_write(CFG_DIGIT_COUNT, 64'd15);
        add_write(CFG_ADD_CHECKSUM, 64'd1);
        add_write(CFG_RESP_CAP, 64'd255);
        add_item(64'd2); add_item('1);
        // Buffer too small, by one byte and at zero capacity.
        add_write(CFG_RESP_CAP, 64'd16);
        add_item(64'd3);
        add_write(CFG_RESP_CAP, 64'd0);
        add_item(64'd4);
        // No code digits, with and without a check digit.
        add_write(CFG_RESP_CAP, 64'd2);
        add_write(CFG_DIGIT_COUNT, 64'd0);
        add_item(64'd5);
        add_write(CFG_ADD_CHECKSUM, 64'd0);
        add_item(64'd6);
        // All-ones key and top-bit data on the wider write fields.
        add_write(CFG_KEY_UPPER, '1);
        add_write(CFG_KEY_MIDDLE, '1);
        add_write(CFG_KEY_LOWER, '1);
        add_write(CFG_DIGIT_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
        add_write(CFG_RESP_CAP, 64'hFF);
        add_item(64'd7); add_item(64'hAAAA_5555_AAAA_5555);

        // Random phases with fresh settings and idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            add_write(CFG_KEY_UPPER, rand64());
            add_write(CFG_KEY_MIDDLE, rand64());
            add_write(CFG_KEY_LOWER, $urandom_range(0, 3) == 0 ? 64'h0 : rand64());
            nd = 4'($urandom_range(0, 15));
            add_write(CFG_DIGIT_COUNT, 64'(nd));
            add_write(CFG_ADD_CHECKSUM, 64'($urandom_range(0, 1)));
            add_write(CFG_RESP_CAP, $urandom_range(0, 3) == 0
                                    ? 64'($urandom_range(0, 255))
                                    : 64'(nd + $urandom_range(0, 4)));
            for (int i = 0; i < 53; i++)
                add_item(rand_counter(), i == 26);
        end
        stim_done = 1;
    end

    // Idling mix per stimulus phase, chosen from the number of queued words.
    always @(negedge i_clk) begin
        case ((pending.size() / 60) % 4)
            0: begin send_idle <= 0;  recv_stall <= 0;  end
            1: begin send_idle <= 69; recv_stall <= 0;  end
            2: begin send_idle <= 0;  recv_stall <= 69; end
            default: begin send_idle <= 18; recv_stall <= 18; end
        endcase
    end

    // Handshakes completed at each rising edge, seen by the driver at the next falling edge.
    always @(posedge i_clk) begin
        s_acc <= s_axis_tvalid && s_axis_tready;
        c_acc <= i_cfg_valid && o_cfg_ready;
    end

    // Driver: counter words and register writes, issued at the falling edge.
    int quiet = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            i_cfg_valid <= 0;
        end else begin
            // An offered word stays until a rising edge has taken it.
            automatic bit s_busy = s_axis_tvalid && !s_acc;
            automatic bit c_busy = i_cfg_valid && !c_acc;
            if (!s_busy && !c_busy) begin
                if (pending.size() != 0 && pending[0].drain && expected_codes.size() != 0) begin
                    s_axis_tvalid <= 0; i_cfg_valid <= 0; quiet <= 0;
                end else if (pending.size() != 0 && pending[0].drain && quiet < 400) begin
                    // Idle spacing so no work is left inside the block.
                    s_axis_tvalid <= 0; i_cfg_valid <= 0; quiet <= quiet + 1;
                end else if (pending.size() != 0
                             && (pending[0].drain || $urandom_range(1, 100) > send_idle)) begin
                    if (pending[0].is_cfg) begin
                        i_cfg_valid <= 1;
                        i_cfg_index <= pending[0].idx;
                        i_cfg_data <= pending[0].data;
                        s_axis_tvalid <= 0;
                    end else begin
                        s_axis_tvalid <= 1;
                        s_axis_tdata <= pending[0].data;
                        i_cfg_valid <= 0;
                    end
                    pending.pop_front();
                    quiet <= 0;
                end else begin
                    s_axis_tvalid <= 0;
                    i_cfg_valid <= 0;
                end
            end
        end
    end

    // Receiver readiness with one long hold-off while the sender keeps offering.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else if (hold_off > 0) begin
            m_axis_tready <= 0;
            hold_off <= hold_off - 1;
        end else if (!held && pending.size() <= 300 && s_axis_tvalid) begin
            m_axis_tready <= 0;
            hold_off <= 3000;
            held <= 1;
        end else begin
            m_axis_tready <= ($urandom_range(1, 100) > recv_stall);
        end
    end

    // Monitor: accepted writes update the shadow, accepted words are predicted,
    // and accepted results are checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_code got, want;
        if (!i_rst_n) begin
            key_hi <= 0; key_mid <= 0; key_lo <= 0;
            num_digits <= 6; want_luhn <= 0; buf_size <= 17;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_KEY_UPPER:    key_hi <= i_cfg_data;
                    CFG_KEY_MIDDLE:   key_mid <= i_cfg_data;
                    CFG_KEY_LOWER:    key_lo <= i_cfg_data[31:0];
                    CFG_DIGIT_COUNT:  num_digits <= i_cfg_data[3:0];
                    CFG_ADD_CHECKSUM: want_luhn <= i_cfg_data[0];
                    CFG_RESP_CAP:     buf_size <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_codes.push_back(hotp_code(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[100:0];
                if (expected_codes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result word %h", got);
                end else begin
                    want = expected_codes.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected st=%0d dig=%h len=%0d tr=%h, got st=%0d dig=%h len=%0d tr=%h",
                                     want.status, want.digits, want.length, want.truncated,
                                     got.status, got.digits, got.length, got.truncated);
                    end
                end
            end
        end
    end

    // Reset, end-of-run wait and the timeout.
    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;
        while (!(stim_done && pending.size() == 0 && !s_axis_tvalid && !i_cfg_valid
                 && expected_codes.size() == 0) && cycles < 1200000) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= 1200000) begin
            $display("Regression FAIL");
        end else begin
            repeat (500) @(posedge i_clk);
            if (errors == 0 && expected_codes.size() == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
        end
        $finish;
    end

endmodule
